FILE: rtl/core/assert_macros.svh
// Assertion shorthands for the sorter; define NO_ASSERTIONS to leave them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset
`define MS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorter assertion failed");
// Check that a condition never holds outside reset
`define MS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sorter forbidden condition seen");
`else
`define MS_ASSERT(lbl, clk, rst_n, prop)
`define MS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/core/msort_pkg.sv
package msort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;
    // Beats buffered between the front and the back; a power of two
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MRD,
        S_MWR,
        S_ERD,
        S_EOUT
    } t_back_state;

    // Oldest queued beat as seen by the back
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_queue_head;

endpackage

FILE: rtl/core/msort_if.sv
interface msort_in_if import msort_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] item_value;
    logic                     item_last;

    modport source (output valid, output item_value, output item_last, input ready);
    modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

interface msort_out_if import msort_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     sorted_last;
    logic                     overflow;

    modport source (output valid, output sorted_value, output sorted_last,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input sorted_last,
                    input overflow, output ready);
endinterface

FILE: rtl/core/msort_front.sv
module msort_front import msort_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msort_in_if.sink    i_in,
    output t_queue_head o_head,
    input  logic        i_pop
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [DATA_W-1:0] r_q_value [QUEUE_DEPTH];
    logic                     r_q_last  [QUEUE_DEPTH];
    logic [PTR_W-1:0]         r_wr_ptr;
    logic [PTR_W-1:0]         r_rd_ptr;
    logic [FILL_W-1:0]        r_fill;
    logic                     push;
    logic                     pop;

    // Take a beat whenever a slot is free
    assign i_in.ready = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_fill != '0);

    // Present the oldest beat to the back
    assign o_head.valid = (r_fill != '0);
    assign o_head.value = r_q_value[r_rd_ptr];
    assign o_head.last  = r_q_last[r_rd_ptr];

    // Store incoming beats
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_value[r_wr_ptr] <= i_in.item_value;
            r_q_last[r_wr_ptr]  <= i_in.item_last;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({push, pop})
                2'b10:   r_fill <= FILL_W'(r_fill + 1'b1);
                2'b01:   r_fill <= FILL_W'(r_fill - 1'b1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/core/msort_back.sv
`include "assert_macros.svh"

module msort_back import msort_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    msort_out_if.source o_out
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = CNT_W + 2;

    // Ping-pong stores: loading fills store 0, each merge pass swaps roles
    logic signed [DATA_W-1:0] mem0 [MAX_ITEMS];
    logic signed [DATA_W-1:0] mem1 [MAX_ITEMS];

    t_back_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drop, n_drop;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_width, n_width;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_sel, n_sel;

    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_ovf;
    logic                     out_load;

    logic signed [DATA_W-1:0] r_rd0a, r_rd0b, r_rd1a, r_rd1b;
    logic signed [DATA_W-1:0] rd_a, rd_b;
    logic [IDX_W-1:0]         addr_a, addr_b;

    logic                     wr0, wr1;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    logic             take_i;
    logic [SUM_W-1:0] wd;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] k_inc;

    // Clip a segment bound to the run length
    function automatic logic [CNT_W-1:0] f_bound(input logic [CNT_W-1:0] lo,
                                                 input logic [SUM_W-1:0] span,
                                                 input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(lo) + span;
        if (sum > SUM_W'(n)) begin
            return n;
        end
        return sum[CNT_W-1:0];
    endfunction

    // Read both stores at two addresses, data registered
    assign addr_a = (r_state == S_ERD || r_state == S_EOUT) ? r_k[IDX_W-1:0]
                                                            : r_i[IDX_W-1:0];
    assign addr_b = r_j[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        r_rd0a <= mem0[addr_a];
        r_rd0b <= mem0[addr_b];
        r_rd1a <= mem1[addr_a];
        r_rd1b <= mem1[addr_b];
        if (wr0) begin
            mem0[wr_addr] <= wr_data;
        end
        if (wr1) begin
            mem1[wr_addr] <= wr_data;
        end
    end

    assign rd_a = r_sel ? r_rd1a : r_rd0a;
    assign rd_b = r_sel ? r_rd1b : r_rd0b;

    // Left head wins while it lasts and is strictly smaller, or once the right run is spent
    assign take_i = (r_i < r_mid) && ((r_j >= r_hi) || (rd_a < rd_b));
    assign wd       = SUM_W'(r_width) << 1;
    assign cnt_inc  = CNT_W'(r_count + 1'b1);
    assign k_inc    = CNT_W'(r_k + 1'b1);
    assign out_load = (r_state == S_EOUT) && (!r_out_valid || o_out.ready);

    // Sequencer: load, merge passes, emit
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_n     = r_n;
        n_width = r_width;
        n_i     = r_i;
        n_mid   = r_mid;
        n_j     = r_j;
        n_hi    = r_hi;
        n_k     = r_k;
        n_sel   = r_sel;
        o_pop   = 1'b0;
        wr0     = 1'b0;
        wr1     = 1'b0;
        wr_addr = r_k[IDX_W-1:0];
        wr_data = take_i ? rd_a : rd_b;

        case (r_state)
            S_LOAD: begin
                o_pop = i_head.valid;
                if (i_head.valid) begin
                    // Append while there is room, else flag the drop
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        wr0     = 1'b1;
                        wr_addr = r_count[IDX_W-1:0];
                        wr_data = i_head.value;
                        n_count = cnt_inc;
                    end else begin
                        n_drop  = 1'b1;
                    end
                    if (i_head.last) begin
                        n_n     = n_count;
                        n_width = CNT_W'(1);
                        n_sel   = 1'b0;
                        n_i     = '0;
                        n_k     = '0;
                        n_mid   = f_bound('0, SUM_W'(1), n_count);
                        n_hi    = f_bound('0, SUM_W'(2), n_count);
                        n_j     = n_mid;
                        n_state = (n_count > CNT_W'(1)) ? S_MRD : S_ERD;
                    end
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                // Write the smaller head into the other store
                wr0   = r_sel;
                wr1   = !r_sel;
                n_k   = k_inc;
                n_state = S_MRD;
                if (take_i) begin
                    n_i = CNT_W'(r_i + 1'b1);
                end else begin
                    n_j = CNT_W'(r_j + 1'b1);
                end
                if (k_inc == r_hi) begin
                    if (r_hi == r_n) begin
                        // Pass done: swap stores, then double the run width or start emitting
                        n_sel = !r_sel;
                        if (wd < SUM_W'(r_n)) begin
                            n_width = wd[CNT_W-1:0];
                            n_i     = '0;
                            n_k     = '0;
                            n_mid   = f_bound('0, wd, r_n);
                            n_hi    = f_bound('0, wd << 1, r_n);
                            n_j     = n_mid;
                        end else begin
                            n_k     = '0;
                            n_state = S_ERD;
                        end
                    end else begin
                        // Start the next pair of runs
                        n_i   = r_hi;
                        n_mid = f_bound(r_hi, SUM_W'(r_width), r_n);
                        n_hi  = f_bound(r_hi, SUM_W'(r_width) << 1, r_n);
                        n_j   = n_mid;
                    end
                end
            end
            S_ERD: begin
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (out_load) begin
                    if (k_inc == r_n) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = k_inc;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Hold the result beat until it is taken
    assign n_out_valid = out_load || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= rd_a;
            r_out_last  <= (k_inc == r_n);
            r_out_ovf   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_n         <= '0;
            r_width     <= '0;
            r_i         <= '0;
            r_mid       <= '0;
            r_j         <= '0;
            r_hi        <= '0;
            r_k         <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_n         <= n_n;
            r_width     <= n_width;
            r_i         <= n_i;
            r_mid       <= n_mid;
            r_j         <= n_j;
            r_hi        <= n_hi;
            r_k         <= n_k;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.sorted_last  = r_out_last;
    assign o_out.overflow     = r_out_ovf;

    // Fill level never passes the store depth
    `MS_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(MAX_ITEMS))
    // Merge heads stay inside their runs
    `MS_ASSERT(a_heads_bounded, i_clk, i_rst_n,
               (r_state == S_MWR) |-> ((r_i <= r_mid) && (r_j <= r_hi) && (r_k < r_hi)))
    // Queue is drained only while loading
    `MS_ASSERT(a_pop_in_load, i_clk, i_rst_n, o_pop |-> (r_state == S_LOAD))
    // Emitting the final value of a run empties the store
    `MS_ASSERT(a_run_cleared, i_clk, i_rst_n,
               (out_load && (k_inc == r_n)) |=>
               ((r_count == '0) && !r_drop && (r_state == S_LOAD)))

endmodule

FILE: rtl/core/merge_sorter.sv
// Run sorter for signed 32-bit values. Input beats are taken one per cycle
// while a run loads into a store of MAX_ITEMS entries; beats past capacity
// are dropped and every result of that run carries overflow. The beat with
// item_last starts a bottom-up merge sort over two ping-pong stores in
// ceil(log2(n)) passes, each merge step reading both run heads and then
// writing the smaller one into the other store; then the n values leave in
// ascending order, the last one with sorted_last. A two-beat queue keeps
// accepting input while the sort runs; once full it back-pressures until
// the next run starts loading. No clearing pass is needed after reset.
module merge_sorter import msort_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msort_in_if.sink    i_in,
    msort_out_if.source o_out
);

    t_queue_head head;
    logic        pop;

    msort_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (head),
        .i_pop   (pop)
    );

    msort_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: tb/merge_sorter_tb.sv
module merge_sorter_tb;
    import msort_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_CAP        = MAX_ITEMS_DEF;
    localparam int RX_HOLD_CYCLES = 1500;
    localparam int LATE_CYCLES    = 200;
    localparam int MAX_REPORTS    = 200;

    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef logic signed [DATA_W-1:0] t_word_q[$];

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_sorted_beat;

    logic i_clk;
    logic i_rst_n;

    msort_in_if  in_bus ();
    msort_out_if out_bus ();

    merge_sorter #(
        .MAX_ITEMS(RUN_CAP)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // Predictor state: the run being loaded and the sorted beats still due
    logic signed [DATA_W-1:0] run_in_store[$];
    logic                     run_dropped;
    t_sorted_beat             sorted_due[$];

    int  fail_count;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  rx_hold_reqs;

    // Free-running clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    // Store one accepted value; on the final one, sort the run and queue its beats
    task automatic predict_sorted_run(input logic signed [DATA_W-1:0] v, input logic l);
        logic signed [DATA_W-1:0] ordered[$];
        t_sorted_beat             beat;
        int                       pos;
        if (run_in_store.size() < RUN_CAP) begin
            run_in_store.push_back(v);
        end else begin
            run_dropped = 1'b1;
        end
        if (l) begin
            ordered = {};
            foreach (run_in_store[i]) begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos] <= run_in_store[i]) pos++;
                ordered.insert(pos, run_in_store[i]);
            end
            foreach (ordered[k]) begin
                beat.value = ordered[k];
                beat.last  = (k == ordered.size() - 1);
                beat.ovf   = run_dropped;
                sorted_due.push_back(beat);
            end
            run_in_store = {};
            run_dropped  = 1'b0;
        end
    endtask

    // Offer one beat, with an optional idle burst first, and wait until taken
    task automatic offer_value(input logic signed [DATA_W-1:0] v, input logic l);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.item_value <= v;
        in_bus.item_last  <= l;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        predict_sorted_run(v, l);
    endtask

    // Send a whole run, marking the final value
    task automatic send_run(input t_word_q vals);
        foreach (vals[i]) offer_value(vals[i], i == vals.size() - 1);
    endtask

    // Hold the input side until every due beat has come out
    task automatic wait_for_drain();
        in_bus.valid <= 1'b0;
        while (sorted_due.size() != 0) @(posedge i_clk);
    endtask

    // Draw a value biased towards extremes and near-duplicates
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: pick_value = WORD_MIN;
            1: pick_value = WORD_MAX;
            2, 3: pick_value = int'($urandom_range(0, 6)) - 3;
            default: pick_value = $urandom;
        endcase
    endfunction

    // Single values, pairs, extremes, duplicates and presorted runs
    task automatic test_directed_extremes();
        send_run('{WORD_MIN});
        send_run('{WORD_MAX, WORD_MIN});
        send_run('{0, -1, 1, WORD_MAX, WORD_MIN, WORD_MAX, -1, 0});
        send_run('{5, 5, 5});
        send_run('{-3, -2, -1, 0, 1, 2});
        send_run('{WORD_MAX, WORD_MAX - 1, WORD_MIN + 1, WORD_MIN});
        wait_for_drain();
    endtask

    // Fill the store exactly, then overrun it by three values, the final one among them
    task automatic test_store_full();
        t_word_q vals;
        vals = {};
        repeat (RUN_CAP) vals.push_back(pick_value());
        send_run(vals);
        vals = {};
        repeat (RUN_CAP + 3) vals.push_back(pick_value());
        send_run(vals);
        wait_for_drain();
    endtask

    // Stall the output for a long stretch while the next run keeps arriving
    task automatic test_back_pressure();
        t_word_q vals;
        rx_hold_reqs <= rx_hold_reqs + 1;
        vals = {};
        repeat (20) vals.push_back(pick_value());
        send_run(vals);
        vals = {};
        repeat (12) vals.push_back(pick_value());
        send_run(vals);
        wait_for_drain();
    endtask

    // Random runs, mostly short with a few long ones reaching up to just past capacity
    task automatic test_random_runs(input int item_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < item_budget) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(RUN_CAP - 24, RUN_CAP + 6);
            end else begin
                len = $urandom_range(1, 12);
            end
            for (int k = 0; k < len; k++) offer_value(pick_value(), k == len - 1);
            sent += len;
        end
        wait_for_drain();
    endtask

    // Receiver: check each beat taken and drive ready with stalls and holds
    initial begin : rx_side
        t_sorted_beat want;
        int           hold_taken;
        int           hold_left;
        int           stall_left;
        hold_taken    = 0;
        hold_left     = 0;
        stall_left    = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_bus.valid && out_bus.ready) begin
                if (sorted_due.size() == 0) begin
                    report_mismatch("beat with nothing due", out_bus.sorted_value, '0);
                end else begin
                    want = sorted_due.pop_front();
                    if (out_bus.sorted_value !== want.value)
                        report_mismatch("sorted_value", out_bus.sorted_value, want.value);
                    if (out_bus.sorted_last !== want.last)
                        report_mismatch("sorted_last", out_bus.sorted_last, want.last);
                    if (out_bus.overflow !== want.ovf)
                        report_mismatch("overflow", out_bus.overflow, want.ovf);
                end
            end
            // Start a long hold when one is requested
            if (rx_hold_reqs != hold_taken) begin
                hold_taken = rx_hold_reqs;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Give up after a generous fixed time
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, run each test in turn, then settle and judge
    initial begin
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.item_value <= '0;
        in_bus.item_last  <= 1'b0;
        run_dropped  = 1'b0;
        fail_count   = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   <= 1'b1;
        rx_hold_reqs <= 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_store_full();
        test_back_pressure();
        test_random_runs(120);

        // Run the last part flat out
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        test_random_runs(40);

        wait_for_drain();
        repeat (LATE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/msort_pkg.sv
rtl/core/msort_if.sv
rtl/core/msort_front.sv
rtl/core/msort_back.sv
rtl/core/merge_sorter.sv
tb/merge_sorter_tb.sv
